FILE: design/radix_integer_parser_defines.svh
// Assertion macros shared by the radix integer parser checkers.
`ifndef RADIX_INTEGER_PARSER_DEFINES_SVH
`define RADIX_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RIP_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("rip assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RIP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("rip assertion failed");

// Next-cycle implication that is checked through reset as well.
`define RIP_ASSERT_RESET(lbl, clk, pre, post) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("rip reset assertion failed");

`endif

FILE: design/rip_pkg.sv
// Types, constants and codes of the radix integer parser.
package rip_pkg;

    localparam int MAX_LEN  = 4095;
    localparam int POS_W    = $clog2(MAX_LEN + 1);
    localparam int OFFSET_W = 12;
    localparam int VALUE_W  = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_UPPER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_PLUS  = 3'd4;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    localparam logic [5:0] BASE_MIN    = 6'd2;
    localparam logic [5:0] BASE_MAX    = 6'd36;
    localparam logic [5:0] BASE_RESET  = 6'd10;
    localparam logic [7:0] LETTER_OFFS = 8'd10;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_SKIP  = 2'd0,
        K_MINUS = 2'd1,
        K_PLUS  = 2'd2,
        K_DIGIT = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        t_status             status;
        logic [OFFSET_W-1:0] stop_offset;
    } t_out_item;

    // Classified character with the settings that were live when it arrived.
    typedef struct packed {
        t_kind      kind;
        logic [5:0] digit;
        logic       last;
        logic [5:0] base;
        logic       base_ok;
        logic [1:0] value_width;
        logic       signed_mode;
    } t_cls_item;

endpackage

FILE: design/rip_front.sv
// Front end: configuration registers, character decode and sign handling.
module rip_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rip_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rip_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rip_pkg::t_in_item                 i_in_item,
    input  logic                              i_q_full,
    output logic                              o_push,
    output rip_pkg::t_cls_item                o_push_item
);

    logic [5:0] r_base;
    logic [1:0] r_value_width;
    logic       r_signed_mode;
    logic       r_accept_upper;
    logic       r_accept_plus;
    logic       r_at_start, n_at_start;
    logic       r_stopped, n_stopped;

    logic       accept;
    logic       base_ok;
    logic       is_num, is_low, is_up, raw_ok, digit_ok;
    logic [7:0] c, diff;
    logic       first;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid && !i_q_full;
    assign c           = i_in_item.char_code;
    assign first       = r_at_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base         <= rip_pkg::BASE_RESET;
            r_value_width  <= 2'd3;
            r_signed_mode  <= 1'b1;
            r_accept_upper <= 1'b0;
            r_accept_plus  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rip_pkg::CFG_BASE:         r_base         <= i_cfg_data;
                rip_pkg::CFG_VALUE_WIDTH:  r_value_width  <= i_cfg_data[1:0];
                rip_pkg::CFG_SIGNED_MODE:  r_signed_mode  <= i_cfg_data[0];
                rip_pkg::CFG_ACCEPT_UPPER: r_accept_upper <= i_cfg_data[0];
                rip_pkg::CFG_ACCEPT_PLUS:  r_accept_plus  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign base_ok = (r_base >= rip_pkg::BASE_MIN) && (r_base <= rip_pkg::BASE_MAX);
    assign is_num  = (c >= rip_pkg::CH_0) && (c <= rip_pkg::CH_9);
    assign is_low  = (c >= rip_pkg::CH_LA) && (c <= rip_pkg::CH_LZ);
    assign is_up   = r_accept_upper && (c >= rip_pkg::CH_UA) && (c <= rip_pkg::CH_UZ);

    always_comb begin
        priority if (is_num) begin
            diff = c - rip_pkg::CH_0;
        end else if (is_low) begin
            diff = c - rip_pkg::CH_LA + rip_pkg::LETTER_OFFS;
        end else begin
            diff = c - rip_pkg::CH_UA + rip_pkg::LETTER_OFFS;
        end
    end

    assign raw_ok   = is_num || is_low || is_up;
    assign digit_ok = raw_ok && base_ok && (diff[5:0] < r_base);

    always_comb begin
        o_push_item.digit       = diff[5:0];
        o_push_item.last        = i_in_item.last_char;
        o_push_item.base        = r_base;
        o_push_item.base_ok     = base_ok;
        o_push_item.value_width = r_value_width;
        o_push_item.signed_mode = r_signed_mode;
        n_stopped               = r_stopped;
        priority if (r_stopped) begin
            o_push_item.kind = rip_pkg::K_SKIP;
        end else if (first && r_signed_mode && c == rip_pkg::CH_MINUS) begin
            o_push_item.kind = rip_pkg::K_MINUS;
        end else if (first && r_signed_mode && r_accept_plus && c == rip_pkg::CH_PLUS) begin
            o_push_item.kind = rip_pkg::K_PLUS;
        end else if (digit_ok) begin
            o_push_item.kind = rip_pkg::K_DIGIT;
        end else begin
            o_push_item.kind = rip_pkg::K_SKIP;
            n_stopped        = 1'b1;
        end
        n_at_start = 1'b0;
        if (i_in_item.last_char) begin
            n_at_start = 1'b1;
            n_stopped  = 1'b0;
        end
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_stopped  <= 1'b0;
        end else if (accept) begin
            r_at_start <= n_at_start;
            r_stopped  <= n_stopped;
        end
    end

endmodule

FILE: design/rip_queue.sv
// Two-entry queue of classified characters between front and back end.
module rip_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rip_pkg::t_cls_item  i_push_item,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_pop,
    output rip_pkg::t_cls_item  o_item
);

    rip_pkg::t_cls_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(do_pop);
        end
    end

endmodule

FILE: design/rip_back.sv
// Back end: range check, multiply-add accumulation and result register.
module rip_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  rip_pkg::t_cls_item  i_q_item,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rip_pkg::t_out_item  o_out_item
);

    logic [63:0]              r_acc, n_acc;
    logic                     r_neg, n_neg;
    logic [rip_pkg::POS_W-1:0] r_pos, n_pos;
    logic                     r_dig, n_dig;
    logic                     r_ovf, n_ovf;
    logic                     r_out_valid;
    rip_pkg::t_out_item       r_out_item, n_out_item;

    logic        out_free;
    logic        take_result;
    logic [63:0] umax, lim;
    logic [69:0] mac;
    logic        over;
    logic        advance;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = i_q_valid && (!i_q_item.last || out_free);
    assign take_result = o_pop && i_q_item.last;

    always_comb begin
        unique case (i_q_item.value_width)
            2'd0: umax = 64'h0000_0000_0000_00FF;
            2'd1: umax = 64'h0000_0000_0000_FFFF;
            2'd2: umax = 64'h0000_0000_FFFF_FFFF;
            2'd3: umax = 64'hFFFF_FFFF_FFFF_FFFF;
            default: umax = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        lim = i_q_item.signed_mode ? ((umax >> 1) + 64'(r_neg)) : umax;
    end

    // acc*base + d > lim is the same test as the guard/remainder compare, since d < base
    assign mac  = 70'(r_acc) * 70'(i_q_item.base) + 70'(i_q_item.digit);
    assign over = (mac > 70'(lim));

    always_comb begin
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_dig   = r_dig;
        n_ovf   = r_ovf;
        advance = 1'b0;
        unique case (i_q_item.kind)
            rip_pkg::K_MINUS: begin
                n_neg   = 1'b1;
                advance = 1'b1;
            end
            rip_pkg::K_PLUS: begin
                advance = 1'b1;
            end
            rip_pkg::K_DIGIT: begin
                if (!r_ovf) begin
                    if (over) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = mac[63:0];
                    end
                end
                n_dig   = 1'b1;
                advance = 1'b1;
            end
            rip_pkg::K_SKIP: ;
            default: ;
        endcase
        n_pos = r_pos;
        if (advance && (r_pos < rip_pkg::POS_W'(rip_pkg::MAX_LEN))) begin
            n_pos = r_pos + 1'b1;
        end
    end

    always_comb begin
        n_out_item.value       = '0;
        n_out_item.stop_offset = '0;
        priority if (!i_q_item.base_ok || !n_dig) begin
            n_out_item.status = rip_pkg::ST_INVAL;
        end else if (n_ovf) begin
            n_out_item.status      = rip_pkg::ST_RANGE;
            n_out_item.stop_offset = rip_pkg::OFFSET_W'(n_pos);
        end else begin
            n_out_item.status      = rip_pkg::ST_OK;
            n_out_item.stop_offset = rip_pkg::OFFSET_W'(n_pos);
            n_out_item.value       = n_neg ? (64'd0 - n_acc) : n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_neg <= 1'b0;
            r_pos <= '0;
            r_dig <= 1'b0;
            r_ovf <= 1'b0;
        end else if (o_pop) begin
            if (i_q_item.last) begin
                r_acc <= '0;
                r_neg <= 1'b0;
                r_pos <= '0;
                r_dig <= 1'b0;
                r_ovf <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_neg <= n_neg;
                r_pos <= n_pos;
                r_dig <= n_dig;
                r_ovf <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= take_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_result) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: design/radix_integer_parser.sv
// Radix integer parser: one character per item in, one parsed integer per string out.
//
// Input channel: i_in_valid / o_in_stall carry one character and a last-character
// marker; an item is taken at a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry value, status and stop offset,
// one result for each character marked last.
// Configuration: i_cfg_valid / o_cfg_ready with a register index (0 base,
// 1 value width, 2 signed mode, 3 accept upper, 4 accept plus); ready is always
// high. Write only while no string is in flight.
// Throughput: one character per cycle while o_in_stall is low, held by the back end's accumulate step
// (64x6 multiply-add and limit compare feeding the accumulator).
// Result path: with the queue empty, the last character passes through the queue
// entry, then the output register, before the result is valid.
// Stalls: a stalled result holds in the output register; the two-entry queue
// keeps taking characters until it fills, then o_in_stall rises.
// Reset: synchronous, active low; loads the register defaults (base 10,
// 64 bits, signed) and empties the queue and the output register.
module radix_integer_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rip_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  rip_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output rip_pkg::t_out_item             o_out_item
);

    logic               push;
    rip_pkg::t_cls_item push_item;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    rip_pkg::t_cls_item q_item;

    rip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    rip_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .i_pop       (q_pop),
        .o_item      (q_item)
    );

    rip_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: design/rip_checker.sv
// Port-level checks of the radix integer parser and their bind to the top level.
`include "radix_integer_parser_defines.svh"

module rip_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input rip_pkg::t_out_item             o_out_item
);

    `RIP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `RIP_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_out_valid && (o_out_item.status != rip_pkg::ST_OK), o_out_item.value == '0)
    `RIP_ASSERT_NOW(a_inval_offs, i_clk, i_rst_n, o_out_valid && (o_out_item.status == rip_pkg::ST_INVAL), o_out_item.stop_offset == '0)
    `RIP_ASSERT_RESET(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind radix_integer_parser rip_checker u_rip_checker (.*);

FILE: verif/radix_integer_parser_test.sv
// Self-checking testbench for the radix integer parser: string stimulus, parse prediction, result checks.
`timescale 1ns / 1ps

module radix_integer_parser_test;
    import rip_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [5:0] base;
        logic [1:0] width;
        logic       sgn;
        logic       upper;
        logic       plus;
    } t_setting;

    logic clk;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;

    // register shadow, updated when a write is taken
    logic [5:0] cfg_base   = BASE_RESET;
    logic [1:0] cfg_width  = 2'd3;
    logic       cfg_signed = 1'b1;
    logic       cfg_upper  = 1'b0;
    logic       cfg_plus   = 1'b0;

    // per-string parse state
    logic [63:0] acc       = '0;
    logic        neg       = 1'b0;
    int          pos       = 0;
    logic        had_digit = 1'b0;
    logic        stopped   = 1'b0;
    logic        ovf       = 1'b0;
    logic        at_start  = 1'b1;

    t_in_item  pending_chars[$];
    t_out_item expected_results[$];

    int in_idle_pct  = 21;
    int out_idle_pct = 21;
    int hold_serial  = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;

    radix_integer_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic base_valid();
        return cfg_base >= BASE_MIN && cfg_base <= BASE_MAX;
    endfunction

    function automatic logic [63:0] width_limit(logic [1:0] w, logic sgn, logic is_neg);
        logic [63:0] lim;
        lim = (w == 2'd3) ? {64{1'b1}} : ((64'd1 << (8 << w)) - 64'd1);
        if (sgn) begin
            lim = lim >> 1;
            if (is_neg) lim = lim + 64'd1;
        end
        return lim;
    endfunction

    // digit value of a character under the live settings, -1 if it is not a digit
    function automatic int digit_value(logic [7:0] c);
        int d;
        d = -1;
        if (c >= CH_0 && c <= CH_9) d = int'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LZ) d = int'(c - CH_LA) + 10;
        else if (cfg_upper && c >= CH_UA && c <= CH_UZ) d = int'(c - CH_UA) + 10;
        if (!base_valid() || d >= int'(cfg_base)) d = -1;
        return d;
    endfunction

    task automatic parse_char(t_in_item it);
        int          d;
        logic        first;
        logic [63:0] lim;
        logic [63:0] guard;
        logic [63:0] rem;
        t_out_item   want;
        first = at_start;
        at_start = 1'b0;
        if (!stopped) begin
            if (first && cfg_signed && it.char_code == CH_MINUS) begin
                neg = 1'b1;
                if (pos < MAX_LEN) pos++;
            end else if (first && cfg_signed && cfg_plus && it.char_code == CH_PLUS) begin
                if (pos < MAX_LEN) pos++;
            end else begin
                d = digit_value(it.char_code);
                if (d < 0) begin
                    stopped = 1'b1;
                end else begin
                    // once out of range, digits are still counted but not added
                    if (!ovf) begin
                        lim   = width_limit(cfg_width, cfg_signed, neg);
                        guard = lim / 64'(cfg_base);
                        rem   = lim % 64'(cfg_base);
                        if (acc > guard || (acc == guard && 64'(d) > rem)) ovf = 1'b1;
                        else acc = acc * 64'(cfg_base) + 64'(d);
                    end
                    had_digit = 1'b1;
                    if (pos < MAX_LEN) pos++;
                end
            end
        end
        if (it.last_char) begin
            want = '0;
            if (!base_valid() || !had_digit) begin
                want.status = ST_INVAL;
            end else if (ovf) begin
                want.status      = ST_RANGE;
                want.stop_offset = OFFSET_W'(pos);
            end else begin
                want.status      = ST_OK;
                want.stop_offset = OFFSET_W'(pos);
                want.value       = neg ? 64'd0 - acc : acc;
            end
            expected_results.push_back(want);
            acc       = '0;
            neg       = 1'b0;
            pos       = 0;
            had_digit = 1'b0;
            stopped   = 1'b0;
            ovf       = 1'b0;
            at_start  = 1'b1;
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s at %0t: got %0h, expected %0h", what, $time, got, want);
        mismatches++;
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with none pending, value", got.value, 64'd0);
            return;
        end
        want = expected_results.pop_front();
        if (got.value != want.value) report_mismatch("value", got.value, want.value);
        if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.stop_offset != want.stop_offset)
            report_mismatch("stop_offset", 64'(got.stop_offset), 64'(want.stop_offset));
    endtask

    // sender: holds an item while stalled, otherwise offers the next one or idles
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) parse_char(in_item);
            if (!in_valid || !in_stall) begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    in_valid <= 1'b1;
                    in_item  <= pending_chars.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks taken results, stalls at random or for a long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) check_result(out_item);
            if (hold_serial != hold_seen) begin
                hold_seen = hold_serial;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_string(input logic [7:0] text[$]);
        foreach (text[i])
            pending_chars.push_back('{char_code: text[i], last_char: (i == text.size() - 1)});
    endtask

    task automatic add_run(string prefix, logic [7:0] ch, int count);
        logic [7:0] text[$];
        for (int i = 0; i < prefix.len(); i++) text.push_back(prefix[i]);
        repeat (count) text.push_back(ch);
        push_string(text);
    endtask

    task automatic add_text(string s);
        add_run(s, CH_0, 0);
    endtask

    function automatic logic [7:0] digit_char(int d);
        if (d < 10) return CH_0 + 8'(d);
        if (cfg_upper && $urandom_range(1) != 0) return CH_UA + 8'(d - 10);
        return CH_LA + 8'(d - 10);
    endfunction

    function automatic logic [7:0] junk_char();
        if ($urandom_range(3) == 0) return ($urandom_range(1) != 0) ? CH_MINUS : CH_PLUS;
        return 8'($urandom_range(255));
    endfunction

    // mostly well-formed numbers, some at the width limit, the rest broken or noise
    task automatic fill_random(int n_chars);
        logic [7:0]  text[$];
        int          sent;
        int          kind;
        int          n;
        int          eff_base;
        int          r;
        logic        is_neg;
        logic [63:0] v;
        sent = 0;
        eff_base = base_valid() ? int'(cfg_base) : 36;
        while (sent < n_chars) begin
            text.delete();
            kind = $urandom_range(99);
            if (kind < 15 && base_valid()) begin
                is_neg = cfg_signed && ($urandom_range(1) != 0);
                v = width_limit(cfg_width, cfg_signed, is_neg);
                if ($urandom_range(2) == 0 && v != {64{1'b1}}) v = v + 64'd1;
                else v = v - 64'($urandom_range(2));
                do begin
                    text.push_front(digit_char(int'(v % 64'(cfg_base))));
                    v = v / 64'(cfg_base);
                end while (v != 0);
                if (is_neg) text.push_front(CH_MINUS);
                else if (cfg_signed && $urandom_range(3) == 0) text.push_front(CH_PLUS);
            end else if (kind < 85) begin
                r = $urandom_range(99);
                if (cfg_signed && r < 30) text.push_back(CH_MINUS);
                else if (cfg_signed && r < 45) text.push_back(CH_PLUS);
                else if (!cfg_signed && r < 10) text.push_back(junk_char());
                n = ($urandom_range(9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 6);
                repeat (n) text.push_back(digit_char($urandom_range(eff_base - 1)));
                // stop characters after the digits
                if (kind >= 65) repeat ($urandom_range(1, 3)) text.push_back(junk_char());
            end else begin
                repeat ($urandom_range(1, 5)) text.push_back(junk_char());
            end
            push_string(text);
            sent += text.size();
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BASE:         cfg_base   = data;
            CFG_VALUE_WIDTH:  cfg_width  = data[1:0];
            CFG_SIGNED_MODE:  cfg_signed = data[0];
            CFG_ACCEPT_UPPER: cfg_upper  = data[0];
            CFG_ACCEPT_PLUS:  cfg_plus   = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(t_setting s);
        write_reg(CFG_BASE, s.base);
        write_reg(CFG_VALUE_WIDTH, CFG_DATA_W'(s.width));
        write_reg(CFG_SIGNED_MODE, CFG_DATA_W'(s.sgn));
        write_reg(CFG_ACCEPT_UPPER, CFG_DATA_W'(s.upper));
        write_reg(CFG_ACCEPT_PLUS, CFG_DATA_W'(s.plus));
        cfg_valid <= 1'b0;
    endtask

    // wait until every item is taken and every result checked, then let the pipe drain
    task automatic settle();
        do @(negedge clk);
        while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        t_setting plan[11];
        plan[0]  = '{6'd2,  2'd3, 1'b0, 1'b0, 1'b0};
        plan[1]  = '{6'd36, 2'd0, 1'b1, 1'b1, 1'b1};
        plan[2]  = '{6'd10, 2'd0, 1'b0, 1'b0, 1'b0};
        plan[3]  = '{6'd16, 2'd1, 1'b0, 1'b1, 1'b0};
        plan[4]  = '{6'd8,  2'd2, 1'b1, 1'b0, 1'b1};
        plan[5]  = '{6'd37, 2'd3, 1'b1, 1'b1, 1'b1};
        plan[6]  = '{6'd0,  2'd1, 1'b0, 1'b0, 1'b1};
        plan[7]  = '{6'd1,  2'd2, 1'b1, 1'b1, 1'b0};
        plan[8]  = '{6'd63, 2'd3, 1'b0, 1'b1, 1'b1};
        for (int i = 9; i < 11; i++)
            plan[i] = '{6'($urandom_range(2, 36)), 2'($urandom_range(3)),
                        1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1))};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: base 10, 64-bit signed
        add_text("0");
        add_text("9223372036854775807");
        add_text("-9223372036854775808");
        add_text("9223372036854775808");
        add_text("-9223372036854775809");
        add_text("+7");
        add_text("-");
        add_text("--5");
        add_text("12x4");
        add_text("A");
        add_run("", 8'hFF, 1);
        add_run("", 8'h00, 1);
        fill_random(100);
        settle();

        for (int ph = 0; ph < 11; ph++) begin
            set_config(plan[ph]);
            @(negedge clk);
            case (ph)
                0: begin
                    add_run("", CH_0 + 8'd1, 64);
                    add_run("", CH_0 + 8'd1, 65);
                    add_text("-1");
                end
                1: begin
                    add_text("3j");
                    add_text("-3K");
                    add_text("3k");
                    add_text("+Z");
                    add_text("--1");
                end
                2: begin
                    add_text("255");
                    add_text("256");
                    add_text("+1");
                end
                3: begin
                    add_text("FFFF");
                    add_text("ffff0");
                end
                4: begin
                    add_text("-20000000000");
                    add_text("17777777777");
                    add_text("+8");
                end
                5, 6, 7, 8: add_text("1");
                9: hold_serial++;
                10: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
                default: ;
            endcase
            fill_random((ph >= 5 && ph <= 8) ? 40 : (ph >= 9 ? 110 : 55));
            settle();
            in_idle_pct  = 21;
            out_idle_pct = 21;
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/rip_pkg.sv
design/rip_front.sv
design/rip_queue.sv
design/rip_back.sv
design/radix_integer_parser.sv
design/rip_checker.sv
verif/radix_integer_parser_test.sv
